// ===== rtl/wrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// WAV RIFF header parser package
// Shared payload types, parser phases, status codes and header constants.
// ----------------------------------------------------------------------------
package wrhp_pkg;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] avg_bytes_per_sec;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] data_offset;
        logic [31:0] data_size;
    } t_out;

    typedef struct packed {
        logic valid;
        t_out data;
    } t_res_push;

    typedef enum logic [3:0] {
        PH_MAGIC = 4'b0001,
        PH_WALK  = 4'b0010,
        PH_FMT   = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_UNSUPP    = 3'd2;
    localparam logic [2:0] ST_MISSING   = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    // Four-character codes, first file byte in the low lane.
    localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
    localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
    localparam logic [31:0] NAME_FMT   = 32'h2074_6D66;
    localparam logic [31:0] NAME_DATA  = 32'h6174_6164;

    localparam logic [31:0] FIRST_CHUNK  = 32'd12;
    localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
    localparam logic [31:0] CHUNK_HDR    = 32'd8;
    localparam logic [31:0] OFS_MAX      = 32'hFFFF_FFFF;

endpackage

// ===== rtl/wrhp_core.sv =====
// ----------------------------------------------------------------------------
// WAV RIFF header parser core
// Per-byte parse state: magic check, chunk walk and fmt field capture.
// ----------------------------------------------------------------------------
module wrhp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  wrhp_pkg::t_in     i_in,
    output wrhp_pkg::t_res_push o_push
);

    wrhp_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_offset, n_offset;
    logic [31:0] r_next_chunk, n_next_chunk;
    logic [63:0] r_hdr, n_hdr;
    logic [15:0] r_channels, n_channels;
    logic [31:0] r_rate, n_rate;
    logic [31:0] r_avg_rate, n_avg_rate;
    logic [15:0] r_align, n_align;
    logic [15:0] r_bits, n_bits;
    logic [31:0] r_data_offset, n_data_offset;
    logic [31:0] r_data_size, n_data_size;
    logic [1:0]  r_found, n_found;

    logic [7:0]  w_byte;
    logic [31:0] w_rel;
    logic [4:0]  w_fmt_rel;
    logic [33:0] w_chunk_end;
    logic        w_finish;
    logic        w_dec;
    logic        w_emit;
    logic [2:0]  w_status;

    assign w_byte      = i_in.file_byte;
    assign w_rel       = r_offset - r_next_chunk;
    assign w_fmt_rel   = r_offset[4:0] - r_next_chunk[4:0];
    assign w_chunk_end = {2'b00, r_next_chunk} + {2'b00, r_hdr[63:32]}
                       + {2'b00, wrhp_pkg::CHUNK_HDR};

    always_comb begin
        n_phase       = r_phase;
        n_offset      = r_offset;
        n_next_chunk  = r_next_chunk;
        n_hdr         = r_hdr;
        n_channels    = r_channels;
        n_rate        = r_rate;
        n_avg_rate    = r_avg_rate;
        n_align       = r_align;
        n_bits        = r_bits;
        n_data_offset = r_data_offset;
        n_data_size   = r_data_size;
        n_found       = r_found;
        w_finish      = 1'b0;
        w_dec         = 1'b0;
        w_emit        = 1'b0;
        w_status      = wrhp_pkg::ST_OK;

        unique case (r_phase)
            wrhp_pkg::PH_MAGIC: begin
                if (r_offset < 32'd4 &&
                    w_byte != wrhp_pkg::MAGIC_RIFF[{r_offset[1:0], 3'b000} +: 8]) begin
                    w_dec    = 1'b1;
                    w_status = wrhp_pkg::ST_BAD_MAGIC;
                end else if (r_offset >= 32'd8 && r_offset < 32'd12 &&
                    w_byte != wrhp_pkg::MAGIC_WAVE[{r_offset[1:0], 3'b000} +: 8]) begin
                    w_dec    = 1'b1;
                    w_status = wrhp_pkg::ST_BAD_MAGIC;
                end else if (r_offset == 32'd11) begin
                    n_phase      = wrhp_pkg::PH_WALK;
                    n_next_chunk = wrhp_pkg::FIRST_CHUNK;
                end
            end
            wrhp_pkg::PH_WALK: begin
                if (r_offset >= r_next_chunk) begin
                    if (w_rel < wrhp_pkg::CHUNK_HDR) begin
                        n_hdr = {w_byte, r_hdr[63:8]};
                    end else if (r_hdr[31:0] == wrhp_pkg::NAME_FMT) begin
                        if (r_hdr[63:32] < wrhp_pkg::FMT_MIN_SIZE) begin
                            w_dec    = 1'b1;
                            w_status = wrhp_pkg::ST_UNSUPP;
                        end else begin
                            n_hdr   = {r_hdr[63:32], 24'd0, w_byte};
                            n_phase = wrhp_pkg::PH_FMT;
                        end
                    end else begin
                        if (r_hdr[31:0] == wrhp_pkg::NAME_DATA) begin
                            n_data_offset = r_offset;
                            n_data_size   = r_hdr[63:32];
                            n_found[1]    = 1'b1;
                        end
                        w_finish = 1'b1;
                    end
                end
            end
            wrhp_pkg::PH_FMT: begin
                unique case (w_fmt_rel)
                    5'd9: begin
                        if ({w_byte, r_hdr[7:0]} != 16'd1) begin
                            w_dec    = 1'b1;
                            w_status = wrhp_pkg::ST_UNSUPP;
                        end
                    end
                    5'd10: n_channels[7:0]   = w_byte;
                    5'd11: n_channels[15:8]  = w_byte;
                    5'd12: n_rate[7:0]       = w_byte;
                    5'd13: n_rate[15:8]      = w_byte;
                    5'd14: n_rate[23:16]     = w_byte;
                    5'd15: n_rate[31:24]     = w_byte;
                    5'd16: n_avg_rate[7:0]   = w_byte;
                    5'd17: n_avg_rate[15:8]  = w_byte;
                    5'd18: n_avg_rate[23:16] = w_byte;
                    5'd19: n_avg_rate[31:24] = w_byte;
                    5'd20: n_align[7:0]      = w_byte;
                    5'd21: n_align[15:8]     = w_byte;
                    5'd22: n_bits[7:0]       = w_byte;
                    5'd23: begin
                        n_bits[15:8] = w_byte;
                        n_found[0]   = 1'b1;
                        w_finish     = 1'b1;
                    end
                    default: ;
                endcase
            end
            wrhp_pkg::PH_DONE: ;
            default: ;
        endcase

        if (w_finish) begin
            if (n_found == 2'b11) begin
                w_dec    = 1'b1;
                w_status = wrhp_pkg::ST_OK;
            end else if (w_chunk_end[33:32] != 2'b00) begin
                w_dec    = 1'b1;
                w_status = wrhp_pkg::ST_TRUNC;
            end else begin
                n_next_chunk = w_chunk_end[31:0];
                n_phase      = wrhp_pkg::PH_WALK;
                // A zero-size chunk: this byte already opens the next header.
                if (w_chunk_end[31:0] == r_offset) begin
                    n_hdr = {w_byte, 56'd0};
                end
            end
        end

        if (r_phase != wrhp_pkg::PH_DONE) begin
            if (w_dec) begin
                w_emit = 1'b1;
            end else if (i_in.is_last) begin
                w_emit = 1'b1;
                w_dec  = 1'b1;
                if (n_phase == wrhp_pkg::PH_MAGIC) begin
                    w_status = wrhp_pkg::ST_BAD_MAGIC;
                end else if (n_phase == wrhp_pkg::PH_FMT) begin
                    w_status = wrhp_pkg::ST_TRUNC;
                end else begin
                    w_status = wrhp_pkg::ST_MISSING;
                end
            end else if (r_offset == wrhp_pkg::OFS_MAX) begin
                w_emit   = 1'b1;
                w_dec    = 1'b1;
                w_status = wrhp_pkg::ST_TRUNC;
            end
        end

        if (w_dec) begin
            n_phase = wrhp_pkg::PH_DONE;
        end

        if (i_in.is_last) begin
            n_phase      = wrhp_pkg::PH_MAGIC;
            n_offset     = 32'd0;
            n_next_chunk = wrhp_pkg::FIRST_CHUNK;
            n_found      = 2'b00;
        end else if (r_offset != wrhp_pkg::OFS_MAX) begin
            n_offset = r_offset + 32'd1;
        end
    end

    always_comb begin
        o_push.valid = i_accept && w_emit;
        o_push.data  = '0;
        o_push.data.status = w_status;
        if (w_status == wrhp_pkg::ST_OK) begin
            o_push.data.channels          = n_channels;
            o_push.data.sample_rate       = n_rate;
            o_push.data.avg_bytes_per_sec = n_avg_rate;
            o_push.data.block_align       = n_align;
            o_push.data.bits_per_sample   = n_bits;
            o_push.data.data_offset       = n_data_offset;
            o_push.data.data_size         = n_data_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= wrhp_pkg::PH_MAGIC;
            r_offset     <= 32'd0;
            r_next_chunk <= wrhp_pkg::FIRST_CHUNK;
            r_found      <= 2'b00;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_offset     <= n_offset;
            r_next_chunk <= n_next_chunk;
            r_found      <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hdr         <= n_hdr;
            r_channels    <= n_channels;
            r_rate        <= n_rate;
            r_avg_rate    <= n_avg_rate;
            r_align       <= n_align;
            r_bits        <= n_bits;
            r_data_offset <= n_data_offset;
            r_data_size   <= n_data_size;
        end
    end

endmodule

// ===== rtl/wrhp_out_buf.sv =====
// ----------------------------------------------------------------------------
// WAV RIFF header parser result buffer
// Output register with one skid entry between the parser and the consumer.
// ----------------------------------------------------------------------------
module wrhp_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wrhp_pkg::t_res_push i_push,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output wrhp_pkg::t_out      o_data
);

    logic           r_out_valid, n_out_valid;
    logic           r_skid_valid, n_skid_valid;
    wrhp_pkg::t_out r_out, n_out;
    wrhp_pkg::t_out r_skid, n_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = i_push.valid;
                n_skid       = i_push.data;
            end else begin
                n_out_valid = i_push.valid;
                n_out       = i_push.data;
            end
        end else if (i_push.valid) begin
            n_skid_valid = 1'b1;
            n_skid       = i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== rtl/wav_riff_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// WAV RIFF header parser
// Parses a RIFF/WAVE PCM header streamed one byte per transfer and reports
// one status result with the fmt fields and the data chunk position.
//
//   Channel  Direction  Handshake                  Payload
//   in       sink       i_in_valid / o_in_ready    i_in_data  (t_in)
//   out      source     o_out_valid / i_out_ready  o_out_data (t_out)
//
// One byte is taken per cycle while input ready is high; the result is registered
// in the output register, or in the skid entry while an earlier result is ahead of it.
// Input ready is registered and drops only while both result slots hold
// results the consumer has not taken.
// Reset is synchronous; no clearing pass follows.
// ----------------------------------------------------------------------------
module wav_riff_header_parser_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wrhp_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output wrhp_pkg::t_out o_out_data
);

    logic                w_accept;
    logic                w_space;
    wrhp_pkg::t_res_push w_push;

    assign o_in_ready = w_space;
    assign w_accept   = i_in_valid && w_space;

    wrhp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_in     (i_in_data),
        .o_push   (w_push)
    );

    wrhp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_space (w_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// ===== test/wav_riff_header_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV RIFF header parser checker
// Watches both channels of the parser. Every byte taken on the input runs
// through a local copy of the header walk, and each status it yields is
// queued. Every result taken on the output is compared field by field with
// the oldest queued status. Counts of failures and outstanding results go to
// the testbench top.
// ----------------------------------------------------------------------------
module wav_riff_header_parser_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  wrhp_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  wrhp_pkg::t_out i_out_data,
    output int             o_errors,
    output int             o_pending,
    output int             o_live_bytes,
    output int             o_results,
    output int             o_ok_results
);

    localparam logic [1:0]  FOUND_FMT  = 2'b01;
    localparam logic [1:0]  FOUND_DATA = 2'b10;
    localparam logic [15:0] TAG_PCM    = 16'd1;

    wrhp_pkg::t_phase stage;
    logic [31:0] pos;
    logic [32:0] chunk_start;
    logic [63:0] hdr;
    logic [15:0] fmt_channels;
    logic [31:0] fmt_rate;
    logic [31:0] fmt_avg_rate;
    logic [15:0] fmt_align;
    logic [15:0] fmt_bits;
    logic [31:0] data_ofs;
    logic [31:0] data_len;
    logic [1:0]  seen;
    logic        settled;
    logic [2:0]  verdict;

    wrhp_pkg::t_out status_due[$];
    int   fail_total     = 0;
    int   live_total     = 0;
    int   results_total  = 0;
    int   ok_total       = 0;

    task automatic restart_parse();
        stage        = wrhp_pkg::PH_MAGIC;
        pos          = '0;
        chunk_start  = {1'b0, wrhp_pkg::FIRST_CHUNK};
        hdr          = '0;
        fmt_channels = '0;
        fmt_rate     = '0;
        fmt_avg_rate = '0;
        fmt_align    = '0;
        fmt_bits     = '0;
        data_ofs     = '0;
        data_len     = '0;
        seen         = '0;
        settled      = 1'b0;
        verdict      = wrhp_pkg::ST_OK;
    endtask

    task automatic settle(input logic [2:0] st);
        settled = 1'b1;
        stage   = wrhp_pkg::PH_DONE;
        verdict = st;
    endtask

    task automatic close_chunk(input logic [32:0] start, input logic [31:0] size);
        logic [33:0] nxt;
        nxt = {1'b0, start} + {2'b0, size} + {2'b0, wrhp_pkg::CHUNK_HDR};
        if (seen == (FOUND_FMT | FOUND_DATA)) begin
            settle(wrhp_pkg::ST_OK);
        end else if (nxt > {2'b0, wrhp_pkg::OFS_MAX}) begin
            settle(wrhp_pkg::ST_TRUNC);
        end else begin
            chunk_start = nxt[32:0];
            stage       = wrhp_pkg::PH_WALK;
        end
    endtask

    task automatic walk_chunks(input logic [7:0] b);
        logic [32:0] start;
        logic [32:0] rel;
        logic [31:0] name;
        logic [31:0] size;
        start = chunk_start;
        if ({1'b0, pos} < start) return;
        rel = {1'b0, pos} - start;
        if (rel < {1'b0, wrhp_pkg::CHUNK_HDR}) begin
            hdr = {b, hdr[63:8]};
            return;
        end
        name = hdr[31:0];
        size = hdr[63:32];
        if (name == wrhp_pkg::NAME_FMT) begin
            if (size < wrhp_pkg::FMT_MIN_SIZE) begin
                settle(wrhp_pkg::ST_UNSUPP);
            end else begin
                hdr   = {size, 24'd0, b};
                stage = wrhp_pkg::PH_FMT;
            end
            return;
        end
        if (name == wrhp_pkg::NAME_DATA) begin
            data_ofs = pos;
            data_len = size;
            seen     = seen | FOUND_DATA;
        end
        close_chunk(start, size);
        if (!settled && chunk_start == {1'b0, pos}) hdr = {b, 56'd0};
    endtask

    task automatic take_fmt_byte(input logic [7:0] b);
        int r;
        r = int'({1'b0, pos} - chunk_start);
        if (r == 9) begin
            if ({b, hdr[7:0]} != TAG_PCM) settle(wrhp_pkg::ST_UNSUPP);
            return;
        end
        if (r >= 10 && r <= 11) fmt_channels[(r - 10) * 8 +: 8] = b;
        else if (r >= 12 && r <= 15) fmt_rate[(r - 12) * 8 +: 8] = b;
        else if (r >= 16 && r <= 19) fmt_avg_rate[(r - 16) * 8 +: 8] = b;
        else if (r >= 20 && r <= 21) fmt_align[(r - 20) * 8 +: 8] = b;
        else if (r >= 22 && r <= 23) fmt_bits[(r - 22) * 8 +: 8] = b;
        if (r == 23) begin
            seen = seen | FOUND_FMT;
            close_chunk(chunk_start, hdr[63:32]);
        end
    endtask

    task automatic parse_byte(input wrhp_pkg::t_in item);
        wrhp_pkg::t_out res;
        logic emit;
        int   lane;
        emit = 1'b0;
        lane = int'(pos[1:0]);
        if (!settled) begin
            live_total++;
            unique case (stage)
                wrhp_pkg::PH_MAGIC: begin
                    if (pos < 32'd4 &&
                        item.file_byte != wrhp_pkg::MAGIC_RIFF[lane * 8 +: 8]) begin
                        settle(wrhp_pkg::ST_BAD_MAGIC);
                    end else if (pos >= 32'd8 && pos < 32'd12 &&
                                 item.file_byte != wrhp_pkg::MAGIC_WAVE[lane * 8 +: 8]) begin
                        settle(wrhp_pkg::ST_BAD_MAGIC);
                    end else if (pos == 32'd11) begin
                        stage       = wrhp_pkg::PH_WALK;
                        chunk_start = {1'b0, wrhp_pkg::FIRST_CHUNK};
                    end
                end
                wrhp_pkg::PH_WALK: walk_chunks(item.file_byte);
                wrhp_pkg::PH_FMT:  take_fmt_byte(item.file_byte);
                default: ;
            endcase
            if (settled) begin
                emit = 1'b1;
            end else if (item.is_last) begin
                if (stage == wrhp_pkg::PH_MAGIC) settle(wrhp_pkg::ST_BAD_MAGIC);
                else if (stage == wrhp_pkg::PH_FMT) settle(wrhp_pkg::ST_TRUNC);
                else settle(wrhp_pkg::ST_MISSING);
                emit = 1'b1;
            end else if (pos == wrhp_pkg::OFS_MAX) begin
                settle(wrhp_pkg::ST_TRUNC);
                emit = 1'b1;
            end
        end
        if (emit) begin
            res        = '0;
            res.status = verdict;
            if (verdict == wrhp_pkg::ST_OK) begin
                res.channels          = fmt_channels;
                res.sample_rate       = fmt_rate;
                res.avg_bytes_per_sec = fmt_avg_rate;
                res.block_align       = fmt_align;
                res.bits_per_sample   = fmt_bits;
                res.data_offset       = data_ofs;
                res.data_size         = data_len;
            end
            status_due.push_back(res);
        end
        if (item.is_last) restart_parse();
        else if (pos != wrhp_pkg::OFS_MAX) pos = pos + 32'd1;
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        end
    endtask

    task automatic compare_result(input wrhp_pkg::t_out got);
        wrhp_pkg::t_out want;
        if (status_due.size() == 0) begin
            fail_total++;
            $display("%0t: unexpected result, expected none, actual status %0d",
                     $time, got.status);
            return;
        end
        want = status_due.pop_front();
        results_total++;
        if (got.status == wrhp_pkg::ST_OK) ok_total++;
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("channels", 32'(want.channels), 32'(got.channels));
        check_field("sample_rate", want.sample_rate, got.sample_rate);
        check_field("avg_bytes_per_sec", want.avg_bytes_per_sec, got.avg_bytes_per_sec);
        check_field("block_align", 32'(want.block_align), 32'(got.block_align));
        check_field("bits_per_sample", 32'(want.bits_per_sample),
                    32'(got.bits_per_sample));
        check_field("data_offset", want.data_offset, got.data_offset);
        check_field("data_size", want.data_size, got.data_size);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_parse();
            status_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) parse_byte(i_in_data);
            if (i_out_valid && i_out_ready) compare_result(i_out_data);
        end
        o_errors     <= fail_total;
        o_pending    <= status_due.size();
        o_live_bytes <= live_total;
        o_results    <= results_total;
        o_ok_results <= ok_total;
    end

endmodule

// ===== test/wav_riff_header_parser_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV RIFF header parser testbench
// Streams short directed files and then randomly built RIFF/WAVE files
// through the parser, one byte per transfer. Files mix fmt, data and other
// chunks in random order, with short, huge and zero sizes, non-PCM tags,
// truncation, corrupted bytes and pure noise. Both sides stall at random;
// the checker beside the parser predicts and compares every result.
// ----------------------------------------------------------------------------
module wav_riff_header_parser_top_test;

    localparam int BYTE_TARGET = 1900;
    localparam int MIN_FILES   = 36;
    localparam int LONG_HOLD   = 600;
    localparam int DRAIN_WAIT  = 20;

    typedef enum logic [1:0] {
        CHUNK_OTHER,
        CHUNK_FMT,
        CHUNK_DATA
    } t_chunk_kind;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    wrhp_pkg::t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    wrhp_pkg::t_out o_out_data;

    int   errors;
    int   pending_results;
    int   live_bytes;
    int   results;
    int   ok_results;

    logic [7:0] file_bytes[$];
    int         files_sent  = 0;
    int         bytes_sent  = 0;
    logic       no_idle     = 1'b0;
    logic       idle_on     = 1'b0;
    logic       long_hold_go = 1'b0;

    wav_riff_header_parser_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    wav_riff_header_parser_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_errors     (errors),
        .o_pending    (pending_results),
        .o_live_bytes (live_bytes),
        .o_results    (results),
        .o_ok_results (ok_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [31:0] pick_field();
        unique case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic push32(input logic [31:0] w);
        for (int k = 0; k < 4; k++) file_bytes.push_back(w[k * 8 +: 8]);
    endtask

    task automatic push16(input logic [15:0] w);
        file_bytes.push_back(w[7:0]);
        file_bytes.push_back(w[15:8]);
    endtask

    task automatic push_random(input int count);
        repeat (count) file_bytes.push_back(8'($urandom));
    endtask

    task automatic add_chunk(input t_chunk_kind kind);
        logic [31:0] size;
        int          mode;
        mode = $urandom_range(0, 99);
        unique case (kind)
            CHUNK_FMT: begin
                push32(wrhp_pkg::NAME_FMT);
                if (mode < 8) begin
                    size = $urandom_range(0, 15);
                    push32(size);
                    push_random(int'(size));
                end else begin
                    if (mode < 12) size = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
                    else size = $urandom_range(16, 22);
                    push32(size);
                    push16(($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'd1);
                    push16(16'(pick_field()));
                    push32(pick_field());
                    push32(pick_field());
                    push16(16'(pick_field()));
                    push16(16'(pick_field()));
                    if (mode >= 12) push_random(int'(size - 32'd16));
                end
            end
            CHUNK_DATA: begin
                push32(wrhp_pkg::NAME_DATA);
                if (mode < 15) begin
                    size = (mode < 3) ? 32'hFFFF_FFFF : ($urandom | 32'h0001_0000);
                    push32(size);
                end else begin
                    size = (mode < 30) ? 32'd0 : 32'($urandom_range(1, 8));
                    push32(size);
                    push_random(int'(size));
                end
            end
            default: begin
                push32($urandom);
                if (mode < 5) begin
                    push32(32'hFFFF_FFF0 | 32'($urandom_range(0, 15)));
                end else begin
                    size = (mode < 30) ? 32'd0 : 32'($urandom_range(1, 8));
                    push32(size);
                    push_random(int'(size));
                end
            end
        endcase
    endtask

    task automatic build_wave_file();
        int         n_fmt;
        int         n_data;
        int         n_other;
        int         pick;
        int         cut;
        int         idx;
        file_bytes.delete();
        if ($urandom_range(0, 19) == 0) begin
            push_random($urandom_range(1, 16));
            if ($urandom_range(0, 1) == 0) file_bytes[0] = wrhp_pkg::MAGIC_RIFF[7:0];
            return;
        end
        push32(wrhp_pkg::MAGIC_RIFF);
        push32($urandom);
        push32(wrhp_pkg::MAGIC_WAVE);
        n_fmt   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 1;
        n_data  = ($urandom_range(0, 9) == 0) ? 0 : 1;
        n_other = $urandom_range(0, 2);
        while (n_fmt + n_data + n_other > 0) begin
            pick = $urandom_range(0, n_fmt + n_data + n_other - 1);
            if (pick < n_fmt) begin
                add_chunk(CHUNK_FMT);
                n_fmt--;
            end else if (pick < n_fmt + n_data) begin
                add_chunk(CHUNK_DATA);
                n_data--;
            end else begin
                add_chunk(CHUNK_OTHER);
                n_other--;
            end
        end
        push_random($urandom_range(1, 4));
        if ($urandom_range(0, 99) < 12) begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut) file_bytes.delete(file_bytes.size() - 1);
        end
        if ($urandom_range(0, 99) < 6) begin
            idx = $urandom_range(0, file_bytes.size() - 1);
            file_bytes[idx] = file_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        wrhp_pkg::t_in item;
        item.file_byte = b;
        item.is_last   = last;
        if (idle_on && !no_idle && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int k = 0; k < file_bytes.size(); k++) begin
            send_byte(file_bytes[k], k == file_bytes.size() - 1);
        end
        files_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    initial begin : out_side
        int hold_cycles;
        int calm_cycles;
        hold_cycles = 0;
        calm_cycles = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_go) begin
                long_hold_go = 1'b0;
                hold_cycles  = LONG_HOLD;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else if (calm_cycles > 0 || no_idle) begin
                if (calm_cycles > 0) calm_cycles--;
                i_out_ready <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                hold_cycles = $urandom_range(0, 18);
                i_out_ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0) calm_cycles = $urandom_range(40, 160);
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : in_side
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bad first magic byte, also the last byte of its file.
        file_bytes.delete();
        file_bytes.push_back(8'h00);
        send_file();
        // File that ends inside the RIFF magic.
        file_bytes.delete();
        for (int k = 0; k < 3; k++) file_bytes.push_back(wrhp_pkg::MAGIC_RIFF[k * 8 +: 8]);
        send_file();
        // Second magic byte wrong.
        file_bytes.delete();
        file_bytes.push_back(wrhp_pkg::MAGIC_RIFF[7:0]);
        file_bytes.push_back(8'hFF);
        send_file();
        // Valid magic with no chunks before the end of the file.
        file_bytes.delete();
        push32(wrhp_pkg::MAGIC_RIFF);
        push32(32'hFFFF_FFFF);
        push32(wrhp_pkg::MAGIC_WAVE);
        file_bytes.push_back(8'hFF);
        send_file();

        while (bytes_sent < BYTE_TARGET || files_sent < MIN_FILES) begin
            if (files_sent == 8) long_hold_go = 1'b1;
            if (bytes_sent >= BYTE_TARGET - 250) no_idle = 1'b1;
            if (files_sent % 12 == 5 && !no_idle) wait_drained();
            idle_on = ($urandom_range(0, 3) != 0);
            build_wave_file();
            send_file();
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Sent %0d files in %0d bytes, %0d of them parsed before a decision.",
                 files_sent, bytes_sent, live_bytes);
        $display("Checked %0d results: %0d accepted headers, %0d rejected.",
                 results, ok_results, results - ok_results);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== wav_riff_header_parser_top.f =====
rtl/wrhp_pkg.sv
rtl/wrhp_core.sv
rtl/wrhp_out_buf.sv
rtl/wav_riff_header_parser_top.sv
test/wav_riff_header_parser_checker.sv
test/wav_riff_header_parser_top_test.sv
